### rtl/apm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_pkg: shared types and constants of the adaptive probability map
// Table geometry, training constants and the training arithmetic.
// ----------------------------------------------------------------------------
package apm_pkg;

  // table geometry
  localparam int CONTEXT_ROWS = 256;
  localparam int ROW_LEN      = 65;
  localparam int TABLE_DEPTH  = CONTEXT_ROWS * ROW_LEN;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int BANK_DEPTH   = (TABLE_DEPTH + 1) / 2;
  localparam int BANK_AW      = $clog2(BANK_DEPTH);
  localparam int COL_W        = $clog2(ROW_LEN);

  // entry and field widths
  localparam int ENTRY_W = 16;
  localparam int PROB_W  = 8;
  localparam int CTX_W   = 8;
  localparam int WGT_W   = 7;
  localparam int ACC_SHIFT = 15;
  localparam int RAMP_SHIFT = 10;

  // training
  localparam int TRAIN_SHIFT = 6;
  localparam logic signed [17:0] TARGET_ONE = 18'sd65598;

  // forwarding of the pair written in the accept cycle
  typedef struct packed {
    logic a_t0;   // new first entry is the old first entry
    logic a_t1;   // new first entry is the old second entry
    logic b_t0;   // new second entry is the old first entry
  } fwd_t;

  // move one entry toward the target of the coded bit, floor-shifted step
  function automatic logic [ENTRY_W-1:0] apm_train(input logic [ENTRY_W-1:0] cur,
                                                   input logic cbit);
    logic signed [17:0] diff;
    logic signed [17:0] step;
    logic [17:0]        sum;
    diff = (cbit ? TARGET_ONE : 18'sd0) - $signed({2'b00, cur});
    step = diff >>> TRAIN_SHIFT;
    sum  = {2'b00, cur} + $unsigned(step);
    return sum[ENTRY_W-1:0];
  endfunction

endpackage

### rtl/apm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_ram: generic simple dual-port ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module apm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/adaptive_probability_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_probability_map_core: secondary estimation stage
// Trains the previous entry pair, looks up and interpolates the new pair.
// ----------------------------------------------------------------------------
// usage
//   in channel: one word per coded bit carrying the input probability, the
//   context byte and the bit that trains the pair chosen by the previous word.
//   out channel: one word per input word, the refined probability.
//   the table lives in two ram banks (even and odd entries) so an entry pair
//   is read and the previous pair written back in the same cycle.
//   the accept cycle issues the ram read and the next cycle selects the pair,
//   so no new word is taken until the lookup of the last word is done.
//   path from input accept to out_tvalid: ram read, lookup and multiply into
//   the product registers, then sum and clip into the output register.
//   reset: a clearing pass writes the ramp j*1024 into every entry (the last
//   column wraps to 0), one entry per cycle, TABLE_DEPTH entries (16640 for
//   256 rows); in_tready is low during the pass.
//   stall: the output register holds its word while out_tready is low; one
//   more word can finish into the product stage, then in_tready drops.
// ----------------------------------------------------------------------------
module adaptive_probability_map_core import apm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // prob_in[7:0], context_req[15:8], coded_bit[16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // prob_out[7:0]
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]   clr_e_r, clr_e_nxt;
  logic [COL_W-1:0]   clr_col_r, clr_col_nxt;
  logic [IDX_W-1:0]   last_r, last_nxt;
  logic [ENTRY_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [ENTRY_W-1:0] t0_r, t1_r;
  fwd_t               fwd_r;
  logic               idx_odd_r;
  logic [WGT_W-1:0]   w_r;
  logic [23:0]        p0_r;
  logic [22:0]        p1_r;
  logic               prod_valid_r, prod_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r;

  // input fields
  logic [PROB_W-1:0] prob_in;
  logic [CTX_W-1:0]  context_req;
  logic              coded_bit;
  assign prob_in     = in_tdata[7:0];
  assign context_req = in_tdata[15:8];
  assign coded_bit   = in_tdata[16];

  logic in_acc, prod_move;
  assign in_acc    = in_tvalid && in_tready;
  assign prod_move = prod_valid_r && (!out_valid_r || out_tready);
  assign in_tready = (state_r == ST_IDLE) && (!prod_valid_r || prod_move);

  // new pair index: row*65 + prob>>2
  logic [CTX_W-1:0] row;
  logic [IDX_W-1:0] new_idx, new_idx_p1, last_p1;
  always_comb begin
    if (CONTEXT_ROWS >= 256) begin
      row = context_req;
    end else begin
      row = CTX_W'(32'(context_req) % CONTEXT_ROWS);
    end
  end
  assign new_idx    = (IDX_W'(row) << 6) + IDX_W'(row) + IDX_W'(prob_in[7:2]);
  assign new_idx_p1 = new_idx + IDX_W'(1);
  assign last_p1    = last_r + IDX_W'(1);

  // trained values of the previous pair
  logic [ENTRY_W-1:0] t0, t1;
  assign t0 = apm_train(a_r, coded_bit);
  assign t1 = apm_train(b_r, coded_bit);

  // bank ports
  logic               ev_we, od_we;
  logic [BANK_AW-1:0] ev_waddr, od_waddr, ev_raddr, od_raddr;
  logic [ENTRY_W-1:0] ev_wdata, od_wdata, ev_rdata, od_rdata;
  logic [IDX_W:0]     last_up, new_up;

  assign last_up  = {1'b0, last_r} + (IDX_W+1)'(1);
  assign new_up   = {1'b0, new_idx} + (IDX_W+1)'(1);
  assign ev_raddr = BANK_AW'(new_up[IDX_W:1]);
  assign od_raddr = BANK_AW'(new_idx[IDX_W-1:1]);

  // write mux: clearing pass or write-back of the trained pair
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ev_we    = !clr_e_r[0];
      od_we    = clr_e_r[0];
      ev_waddr = BANK_AW'(clr_e_r[IDX_W-1:1]);
      od_waddr = BANK_AW'(clr_e_r[IDX_W-1:1]);
      ev_wdata = ENTRY_W'(clr_col_r) << RAMP_SHIFT;
      od_wdata = ENTRY_W'(clr_col_r) << RAMP_SHIFT;
    end else begin
      ev_we    = in_acc;
      od_we    = in_acc;
      ev_waddr = BANK_AW'(last_up[IDX_W:1]);
      od_waddr = BANK_AW'(last_r[IDX_W-1:1]);
      ev_wdata = last_r[0] ? t1 : t0;
      od_wdata = last_r[0] ? t0 : t1;
    end
  end

  apm_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_even (
    .clk(clk), .wr_en(ev_we), .wr_addr(ev_waddr), .wr_data(ev_wdata),
    .rd_en(in_acc), .rd_addr(ev_raddr), .rd_data(ev_rdata)
  );

  apm_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_odd (
    .clk(clk), .wr_en(od_we), .wr_addr(od_waddr), .wr_data(od_wdata),
    .rd_en(in_acc), .rd_addr(od_raddr), .rd_data(od_rdata)
  );

  // pair select in the lookup cycle, with forwarding of the pair just written
  logic [ENTRY_W-1:0] a_sel, b_sel;
  always_comb begin
    a_sel = idx_odd_r ? od_rdata : ev_rdata;
    b_sel = idx_odd_r ? ev_rdata : od_rdata;
    if (fwd_r.a_t0) begin
      a_sel = t0_r;
    end else if (fwd_r.a_t1) begin
      a_sel = t1_r;
    end
    if (fwd_r.b_t0) begin
      b_sel = t0_r;
    end else if (fwd_r.a_t0) begin
      b_sel = t1_r;
    end
  end

  // control next state
  always_comb begin
    state_nxt      = state_r;
    clr_e_nxt      = clr_e_r;
    clr_col_nxt    = clr_col_r;
    last_nxt       = last_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    prod_valid_nxt = prod_valid_r;
    out_valid_nxt  = out_valid_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_e_nxt   = clr_e_r + IDX_W'(1);
        clr_col_nxt = (clr_col_r == COL_W'(ROW_LEN - 1)) ? '0 : clr_col_r + COL_W'(1);
        if (clr_e_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          last_nxt  = new_idx;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        a_nxt     = a_sel;
        b_nxt     = b_sel;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
    // product stage and output register
    if (state_r == ST_LOOK) begin
      prod_valid_nxt = 1'b1;
    end else if (prod_move) begin
      prod_valid_nxt = 1'b0;
    end
    if (prod_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_e_r      <= '0;
      clr_col_r    <= '0;
      last_r       <= '0;
      a_r          <= '0;
      b_r          <= ENTRY_W'(1) << RAMP_SHIFT;
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_e_r      <= clr_e_nxt;
      clr_col_r    <= clr_col_nxt;
      last_r       <= last_nxt;
      a_r          <= a_nxt;
      b_r          <= b_nxt;
      prod_valid_r <= prod_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // accept cycle payload: trained pair, forwarding flags, bank parity, weight
  always_ff @(posedge clk) begin
    if (in_acc) begin
      t0_r       <= t0;
      t1_r       <= t1;
      fwd_r.a_t0 <= (new_idx == last_r);
      fwd_r.a_t1 <= (new_idx == last_p1);
      fwd_r.b_t0 <= (new_idx_p1 == last_r);
      idx_odd_r  <= new_idx[0];
      w_r        <= prob_in[WGT_W-1:0];
    end
  end

  // weighted products
  logic [7:0] w_inv;
  assign w_inv = 8'd128 - {1'b0, w_r};
  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK) begin
      p0_r <= 24'(a_sel) * 24'(w_inv);
      p1_r <= 23'(b_sel) * 23'(w_r);
    end
  end

  // sum, scale and clip into the output register
  logic [24:0] sum;
  logic [9:0]  acc;
  assign sum = {1'b0, p0_r} + {2'b00, p1_r};
  assign acc = sum[24:ACC_SHIFT];
  always_ff @(posedge clk) begin
    if (prod_move) begin
      out_data_r <= (acc > 10'd255) ? 8'hff : acc[7:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // an accepted word always reaches the product stage
  a_prod_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##2 prod_valid_r)
    else $error("accepted word did not reach product stage");

  // a waiting product is never overwritten
  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_valid_r && !prod_move) |=> (prod_valid_r && $stable(p0_r) && $stable(p1_r)))
    else $error("product stage overwritten");

  // no word is taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("accept during clearing pass");

  // the stored pair index always leaves room for the second entry
  a_last_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_r <= IDX_W'(TABLE_DEPTH - 2))
    else $error("pair index out of table");
`endif

endmodule
